// ----- sv/cct_pkg.sv -----
`default_nettype none

package cct_pkg;

  // Query kinds carried by the command field.
  localparam int unsigned CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_POINT   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_SEGMENT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CIRCLE  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED  = 2'd3;

  // Register file: one 32-bit word per register, byte addressed.
  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned ADDR_BITS    = 4;
  localparam int unsigned REG_LSB      = 2;
  localparam int unsigned REG_IDX_BITS = ADDR_BITS - REG_LSB;
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X      = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y      = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CIRCLE_RADIUS = 2'd2;

  // Load strobes of the two register stages inside a split multiplier.
  typedef struct packed {
    logic ld_pp;
    logic ld_sum;
  } mul_ctl_t;

endpackage

`default_nettype wire

// ----- sv/cct_wide_mul.sv -----
`default_nettype none

// Unsigned W x W multiplier split into four half-width partial products.
// The partial products are registered first, then summed into a second register.
module cct_wide_mul #(
  parameter int unsigned W = 34
) (
  input  wire logic                clk_i,
  input  wire cct_pkg::mul_ctl_t   ctl_i,
  input  wire logic [W-1:0]        a_i,
  input  wire logic [W-1:0]        b_i,
  output logic      [2*W-1:0]      p_o
);

  localparam int unsigned H  = W / 2;
  localparam int unsigned HW = W - H;

  logic [2*H-1:0]    ll_q;
  logic [H+HW-1:0]   lh_q;
  logic [H+HW-1:0]   hl_q;
  logic [2*HW-1:0]   hh_q;
  logic [H+HW:0]     mid;
  logic [2*W-1:0]    p_d;
  logic [2*W-1:0]    p_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_pp) begin
      ll_q <= a_i[H-1:0] * b_i[H-1:0];
      lh_q <= a_i[H-1:0] * b_i[W-1:H];
      hl_q <= a_i[W-1:H] * b_i[H-1:0];
      hh_q <= a_i[W-1:H] * b_i[W-1:H];
    end
  end

  always_comb begin
    mid = (H+HW+1)'(lh_q) + (H+HW+1)'(hl_q);
    p_d = ((2*W)'(hh_q) << (2*H)) + ((2*W)'(mid) << H) + (2*W)'(ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sum) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- sv/circle_collision_test_core.sv -----
// Circle collision test: point, segment and circle queries against one configured circle.
// Throughput: one beat per cycle unless the output stalls, set by a six-stage pipeline
// with a multiplier in each of its product stages; bubbles close up under output stall.
// Reset: asynchronous, active low; clears the centre and radius registers to zero and
// empties the pipeline. No clearing pass follows reset.
`default_nettype none

module circle_collision_test_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cct_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [cct_pkg::DATA_BITS-1:0]       pwdata,
  output logic      [cct_pkg::DATA_BITS-1:0]       prdata,
  output logic                                     pready,

  // Query channel.
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [cct_pkg::CMD_BITS-1:0]        command_i,
  input  wire logic signed [COORD_BITS-1:0]        ax_i,
  input  wire logic signed [COORD_BITS-1:0]        ay_i,
  input  wire logic signed [COORD_BITS-1:0]        bx_i,
  input  wire logic signed [COORD_BITS-1:0]        by_i,
  input  wire logic [COORD_BITS-2:0]               other_radius_i,

  // Result channel.
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     hit_o
);

  // Differences of two coordinates need one extra bit; their products, and the sums
  // of two squares, fit in twice that. The long segment products are twice wider again.
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned LW = 2 * DW;
  localparam int unsigned XW = 2 * LW;
  localparam int unsigned NS = 6;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline is
  // idle, as stage one reads them directly; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0]      center_x_q;
  logic signed [COORD_BITS-1:0]      center_y_q;
  logic        [COORD_BITS-2:0]      circle_radius_q;
  logic        [cct_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                              cfg_wr;

  assign reg_idx = paddr[cct_pkg::ADDR_BITS-1:cct_pkg::REG_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      circle_radius_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cct_pkg::REG_CENTER_X:      center_x_q      <= pwdata[COORD_BITS-1:0];
        cct_pkg::REG_CENTER_Y:      center_y_q      <= pwdata[COORD_BITS-1:0];
        cct_pkg::REG_CIRCLE_RADIUS: circle_radius_q <= pwdata[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cct_pkg::REG_CENTER_X:
        prdata = cct_pkg::DATA_BITS'($unsigned(center_x_q));
      cct_pkg::REG_CENTER_Y:
        prdata = cct_pkg::DATA_BITS'($unsigned(center_y_q));
      cct_pkg::REG_CIRCLE_RADIUS:
        prdata = cct_pkg::DATA_BITS'(circle_radius_q);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage holds a valid bit; a stage loads whenever it is
  // empty or the stage after it moves on, so a stalled result only backs up the
  // pipeline once every stage is full.
  // ---------------------------------------------------------------------------
  logic [NS:1]   v_q;
  logic [NS:1]   v_d;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = !out_stall_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (rdy[1]) begin
      v_d[1] = in_valid_i;
    end
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = v_q[NS];

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate differences relative to the centre and along the segment,
  // and the sum of the two radii.
  // ---------------------------------------------------------------------------
  logic [cct_pkg::CMD_BITS-1:0] cmd_q1;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, abx_q, aby_q;
  logic signed [DW-1:0] rad_q, rsum_q;
  logic [COORD_BITS-1:0] rsum;

  assign rsum = COORD_BITS'(circle_radius_q) + COORD_BITS'(other_radius_i);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      cmd_q1 <= command_i;
      dax_q  <= DW'(ax_i) - DW'(center_x_q);
      day_q  <= DW'(ay_i) - DW'(center_y_q);
      dbx_q  <= DW'(bx_i) - DW'(center_x_q);
      dby_q  <= DW'(by_i) - DW'(center_y_q);
      abx_q  <= DW'(bx_i) - DW'(ax_i);
      aby_q  <= DW'(by_i) - DW'(ay_i);
      rad_q  <= $signed(DW'(circle_radius_q));
      rsum_q <= $signed(DW'(rsum));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: one multiplier per product. The dot products are taken with the
  // vector from the centre to the start point, so the sign is folded in later.
  // ---------------------------------------------------------------------------
  logic [cct_pkg::CMD_BITS-1:0] cmd_q2;
  logic signed [LW-1:0] ax2_q, ay2_q, bx2_q, by2_q, abx2_q, aby2_q;
  logic signed [LW-1:0] xab_q, yab_q, r2_q2, rs2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      cmd_q2 <= cmd_q1;
      ax2_q  <= dax_q * dax_q;
      ay2_q  <= day_q * day_q;
      bx2_q  <= dbx_q * dbx_q;
      by2_q  <= dby_q * dby_q;
      abx2_q <= abx_q * abx_q;
      aby2_q <= aby_q * aby_q;
      xab_q  <= dax_q * abx_q;
      yab_q  <= day_q * aby_q;
      r2_q2  <= rad_q * rad_q;
      rs2_q  <= rsum_q * rsum_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distances, the short tests, and the projection range check
  // of the segment test. Only a segment with both end points outside, whose
  // projection of the centre lands on it, needs the long products that follow.
  // ---------------------------------------------------------------------------
  logic [LW-1:0]        pa2, pb2, len, r2u, rs2u;
  logic signed [LW-1:0] dot;
  logic                 in_a, in_b, in_cir, seg_ok, early_d, long_d;

  always_comb begin
    pa2    = $unsigned(ax2_q) + $unsigned(ay2_q);
    pb2    = $unsigned(bx2_q) + $unsigned(by2_q);
    len    = $unsigned(abx2_q) + $unsigned(aby2_q);
    r2u    = $unsigned(r2_q2);
    rs2u   = $unsigned(rs2_q);
    dot    = -(xab_q + yab_q);
    in_a   = pa2 <= r2u;
    in_b   = pb2 <= r2u;
    in_cir = pa2 <= rs2u;
    seg_ok = (len != '0) && !dot[LW-1] && ($unsigned(dot) <= len);
    unique case (cmd_q2)
      cct_pkg::CMD_POINT:   early_d = in_a;
      cct_pkg::CMD_SEGMENT: early_d = in_a || in_b;
      cct_pkg::CMD_CIRCLE:  early_d = in_cir;
      default:              early_d = 1'b0;
    endcase
    long_d = (cmd_q2 == cct_pkg::CMD_SEGMENT) && !in_a && !in_b && seg_ok;
  end

  logic          early_q3, long_q3;
  logic [LW-1:0] pa2_q, len_q, dmag_q, r2_q3;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      early_q3 <= early_d;
      long_q3  <= long_d;
      pa2_q    <= pa2;
      len_q    <= len;
      dmag_q   <= $unsigned(dot);
      r2_q3    <= r2u;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: the three long products, each split into half-width partial
  // products in stage 4 and summed in stage 5.
  // ---------------------------------------------------------------------------
  cct_pkg::mul_ctl_t mul_ctl;
  logic [XW-1:0]     pal, dd, rl;

  assign mul_ctl.ld_pp  = rdy[4];
  assign mul_ctl.ld_sum = rdy[5];

  cct_wide_mul #(.W(LW)) u_mul_pal (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (pa2_q),
    .b_i   (len_q),
    .p_o   (pal)
  );

  cct_wide_mul #(.W(LW)) u_mul_dd (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (dmag_q),
    .b_i   (dmag_q),
    .p_o   (dd)
  );

  cct_wide_mul #(.W(LW)) u_mul_rl (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (r2_q3),
    .b_i   (len_q),
    .p_o   (rl)
  );

  logic early_q4, long_q4, early_q5, long_q5;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      early_q4 <= early_q3;
      long_q4  <= long_q3;
    end
    if (rdy[5]) begin
      early_q5 <= early_q4;
      long_q5  <= long_q4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: the perpendicular test, |AC|^2*L <= r^2*L + d^2, rearranged so that
  // nothing goes negative. This register is the output register.
  // ---------------------------------------------------------------------------
  logic [XW:0] rhs;
  logic        hit_d;
  logic        hit_q;

  always_comb begin
    rhs   = (XW+1)'(rl) + (XW+1)'(dd);
    hit_d = early_q5 || (long_q5 && ((XW+1)'(pal) <= rhs));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

// ----- sv/cct_checker.sv -----
`default_nettype none

module cct_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [cct_pkg::CMD_BITS-1:0] command_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         hit_o
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
    else $error("result beat changed while stalled");

  // The input side only backs up when a result waits and is being held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // With no back-pressure, an accepted beat goes through the whole pipeline and comes out.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result beat late");

  // The unused command never reports a hit.
  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == cct_pkg::CMD_UNUSED)
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> !hit_o)
    else $error("hit reported for unused command");

endmodule

bind circle_collision_test_core cct_checker u_cct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o)
);

`default_nettype wire

// ----- tb/circle_collision_test_core_tb.sv -----
module circle_collision_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS  = 16;
  // The register index just past the list; writes there must change nothing.
  localparam logic [cct_pkg::REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  // Generous cycle budget: the slowest legal run (every beat waiting out the
  // longest source gap and the longest sink stall) is well under a fifth of it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BEATS = 200;

  // Wide enough that |AC|^2 * L and d^2 (both below 2^67) never overflow.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [cct_pkg::CMD_BITS-1:0] command;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [COORD_BITS-2:0]        orad;
  } query_t;

  // One predicted result together with the query that caused it, so that a
  // mismatch report can show what was asked.
  typedef struct {
    query_t q;
    logic   hit;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [cct_pkg::ADDR_BITS-1:0] paddr   = '0;
  logic [cct_pkg::DATA_BITS-1:0] pwdata  = '0;
  logic [cct_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  logic   in_valid  = 1'b0;
  logic   in_stall_o;
  query_t drv_q     = '{default: '0};
  logic   out_valid_o;
  logic   out_stall = 1'b0;
  logic   hit_o;

  // Our own copy of the circle held in the block's registers.
  logic signed [COORD_BITS-1:0] cfg_cx = '0;
  logic signed [COORD_BITS-1:0] cfg_cy = '0;
  logic [COORD_BITS-2:0]        cfg_r  = '0;

  query_t   pending_queries[$];
  verdict_t expected_hits[$];

  // Idling modes: when steady is set that side never pauses, giving
  // stretches of back-to-back beats.
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;

  int unsigned src_gap_left   = 0;
  int unsigned sink_stall_left = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned beats_in       = 0;
  int unsigned beats_out      = 0;
  int unsigned hits_seen      = 0;
  int unsigned circle_setups  = 0;
  int unsigned cmd_count[4]   = '{default: 0};

  circle_collision_test_core #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .command_i     (drv_q.command),
    .ax_i          (drv_q.ax),
    .ay_i          (drv_q.ay),
    .bx_i          (drv_q.bx),
    .by_i          (drv_q.by),
    .other_radius_i(drv_q.orad),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .hit_o         (hit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hit predictor. Everything is widened to 128-bit signed values, so the
  // comparisons are exact, just as the block is meant to be.
  // ---------------------------------------------------------------------------
  function automatic wide_t sq_sum(wide_t x, wide_t y);
    return x * x + y * y;
  endfunction

  function automatic logic predict_hit(query_t q);
    wide_t cx, cy, r, r2, ax, ay, bx, by, ro, s;
    wide_t abx, aby, acx, acy, d, len;
    logic  in_a, in_b;
    cx   = cfg_cx;
    cy   = cfg_cy;
    r    = cfg_r;
    r2   = r * r;
    ax   = q.ax;
    ay   = q.ay;
    bx   = q.bx;
    by   = q.by;
    ro   = q.orad;
    in_a = sq_sum(ax - cx, ay - cy) <= r2;
    in_b = sq_sum(bx - cx, by - cy) <= r2;
    case (q.command)
      cct_pkg::CMD_POINT: begin
        return in_a;
      end
      cct_pkg::CMD_CIRCLE: begin
        s = r + ro;
        return sq_sum(ax - cx, ay - cy) <= s * s;
      end
      cct_pkg::CMD_SEGMENT: begin
        if (in_a || in_b) return 1'b1;
        abx = bx - ax;
        aby = by - ay;
        acx = cx - ax;
        acy = cy - ay;
        d   = acx * abx + acy * aby;
        len = sq_sum(abx, aby);
        // A degenerate segment with both ends outside cannot touch the
        // circle, and the centre must project onto the segment itself.
        if (len == 0 || d < 0 || d > len) return 1'b0;
        return sq_sum(acx, acy) * len - d * d <= r2 * len;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Word that a read of the given register should return.
  function automatic logic [cct_pkg::DATA_BITS-1:0] reg_value(
      logic [cct_pkg::REG_IDX_BITS-1:0] idx);
    case (idx)
      cct_pkg::REG_CENTER_X:
        return {{(cct_pkg::DATA_BITS-COORD_BITS){1'b0}}, cfg_cx};
      cct_pkg::REG_CENTER_Y:
        return {{(cct_pkg::DATA_BITS-COORD_BITS){1'b0}}, cfg_cy};
      cct_pkg::REG_CIRCLE_RADIUS:
        return {{(cct_pkg::DATA_BITS-COORD_BITS+1){1'b0}}, cfg_r};
      default:
        return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_idle(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(int base, int spread);
    return clamp_coord(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic query_t mk_query(logic [cct_pkg::CMD_BITS-1:0] command, int ax,
                                      int ay, int bx, int by, int orad);
    query_t q;
    q.command = command;
    q.ax      = ax[COORD_BITS-1:0];
    q.ay      = ay[COORD_BITS-1:0];
    q.bx      = bx[COORD_BITS-1:0];
    q.by      = by[COORD_BITS-1:0];
    q.orad    = orad[COORD_BITS-2:0];
    return q;
  endfunction

  // Random query. Most coordinates are scattered around the circle within a
  // few radii, so hits and misses are both common and segments often cross
  // the circle with both ends outside; the rest span the whole range.
  function automatic query_t random_query();
    query_t      q;
    int unsigned roll;
    int          spread;
    roll = $urandom_range(0, 99);
    if (roll < 35)      q.command = cct_pkg::CMD_POINT;
    else if (roll < 70) q.command = cct_pkg::CMD_SEGMENT;
    else if (roll < 95) q.command = cct_pkg::CMD_CIRCLE;
    else                q.command = cct_pkg::CMD_UNUSED;
    spread = 3 * int'(cfg_r) + 32;
    if ($urandom_range(0, 9) < 7) begin
      q.ax = near_coord(int'(cfg_cx), spread);
      q.ay = near_coord(int'(cfg_cy), spread);
      q.bx = near_coord(int'(cfg_cx), spread);
      q.by = near_coord(int'(cfg_cy), spread);
    end else begin
      q.ax = COORD_BITS'($urandom);
      q.ay = COORD_BITS'($urandom);
      q.bx = COORD_BITS'($urandom);
      q.by = COORD_BITS'($urandom);
    end
    if ($urandom_range(0, 3) == 0) q.orad = (COORD_BITS-1)'($urandom);
    else q.orad = (COORD_BITS-1)'($urandom_range(0, int'(cfg_r) + 16));
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. A beat moves at an edge where valid is high and stall is
  // low; the prediction is taken there, from the payload that actually moved.
  // The payload is only reloaded once the previous beat has gone.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        expected_hits.push_back('{q: drv_q, hit: predict_hit(drv_q)});
        cmd_count[drv_q.command] = cmd_count[drv_q.command] + 1;
        beats_in++;
      end
      if (!in_valid || !in_stall_o) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          drv_q        <= pending_queries.pop_front();
          in_valid     <= 1'b1;
          src_gap_left = pick_idle(src_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink side: checks every result beat against the oldest prediction and
  // throws in random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        beats_out++;
        if (hit_o === 1'b1) hits_seen++;
        if (expected_hits.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("[%0t] result beat with nothing expected: hit=%b", $realtime, hit_o);
        end else begin
          want = expected_hits.pop_front();
          if (hit_o !== want.hit) begin
            error_count++;
            if (error_count <= 10)
              $display({"[%0t] hit mismatch: cmd=%0d a=(%0d,%0d) b=(%0d,%0d) ro=%0d, ",
                        "circle (%0d,%0d) r=%0d: expected %b, got %b"},
                       $realtime, want.q.command, want.q.ax, want.q.ay, want.q.bx,
                       want.q.by, want.q.orad, cfg_cx, cfg_cy, cfg_r, want.hit, hit_o);
          end
        end
      end
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall       <= 1'b0;
        sink_stall_left = pick_idle(sink_steady);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_hits.size());
      $display("circle_collision_test_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes: a setup cycle, then an access cycle that completes
  // at the edge where pready is seen high. Only ever called with the block
  // idle, so our copy of the circle changes together with the block's. The
  // word is then read back while the address is still on the bus.
  // ---------------------------------------------------------------------------
  task automatic reg_write(input logic [cct_pkg::REG_IDX_BITS-1:0] idx,
                           input logic [cct_pkg::DATA_BITS-1:0]    data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {cct_pkg::REG_LSB{1'b0}}};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cct_pkg::REG_CENTER_X:      cfg_cx = data[COORD_BITS-1:0];
      cct_pkg::REG_CENTER_Y:      cfg_cy = data[COORD_BITS-1:0];
      cct_pkg::REG_CIRCLE_RADIUS: cfg_r  = data[COORD_BITS-2:0];
      default: ;
    endcase
    @(negedge clk_i);
    if (prdata !== reg_value(idx)) begin
      error_count++;
      if (error_count <= 10)
        $display("[%0t] register %0d read back: expected %h, got %h",
                 $realtime, idx, reg_value(idx), prdata);
    end
  endtask

  // Loads a new circle. The upper bits of each word are random, as the block
  // must keep only the register's own width.
  task automatic set_circle(input int cx, input int cy, input int r);
    reg_write(cct_pkg::REG_CENTER_X, {16'($urandom_range(0, 65535)), cx[15:0]});
    reg_write(cct_pkg::REG_CENTER_Y, {16'($urandom_range(0, 65535)), cy[15:0]});
    reg_write(cct_pkg::REG_CIRCLE_RADIUS, {17'($urandom_range(0, 131071)), r[14:0]});
    circle_setups++;
  endtask

  // Waits until the source queue is empty, the last beat has gone in and
  // every prediction has been matched. Sampling on the falling edge keeps
  // clear of the updates made at the rising edge.
  task automatic drain();
    @(negedge clk_i);
    while (pending_queries.size() != 0 || in_valid || expected_hits.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned beats);
    repeat (beats) pending_queries.push_back(random_query());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Straight out of reset the circle is a single point at the origin.
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 0, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 1, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_CIRCLE, 32767, -32768, 0, 0, 32767));
    drain();

    set_circle(100, -200, 50);
    // Boundary is inclusive for points and for touching circles.
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 150, -200, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 151, -200, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, -32768, -32768, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 32767, 32767, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_CIRCLE, 200, -200, 0, 0, 50));
    pending_queries.push_back(mk_query(cct_pkg::CMD_CIRCLE, 200, -200, 0, 0, 49));
    // Segments: an end inside, the other end inside, straight through the
    // centre, passing wide, just grazing, and the centre projecting off
    // either end of the segment.
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 100, -190, 3000, 3000, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, -3000, 2000, 120, -210, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 0, -200, 300, -200, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 0, -100, 300, -100, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 0, -150, 300, -150, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 200, -200, 300, -200, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 300, -200, 200, -200, 0));
    // Degenerate segments, outside and inside.
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 500, 500, 500, 500, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 100, -200, 100, -200, 0));
    // The spare command code never hits, even on the centre itself.
    pending_queries.push_back(mk_query(cct_pkg::CMD_UNUSED, 100, -200, 100, -200, 32767));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, -32768, -32768, 32767, 32767,
                                       0));
    drain();

    // Largest circle in one corner, queried from the opposite corner.
    set_circle(-32768, 32767, 32767);
    pending_queries.push_back(mk_query(cct_pkg::CMD_POINT, 32767, -32768, 0, 0, 0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_CIRCLE, 32767, -32768, 0, 0, 32767));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 32767, -32768, 32767, 32767,
                                       0));
    pending_queries.push_back(mk_query(cct_pkg::CMD_SEGMENT, 32767, -32768, -32768, -32768,
                                       0));
    drain();

    // Random phases. Each one starts from an idle block, which also gives
    // the source a pause until every outstanding result is back.
    set_circle($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
               $urandom_range(0, 600));
    random_phase(PHASE_BEATS);

    src_steady = 1'b1;
    random_phase(PHASE_BEATS);

    set_circle(32767, -32768, 0);
    src_steady = 1'b0;
    random_phase(PHASE_BEATS);

    set_circle($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
               $urandom_range(0, 32767));
    sink_steady = 1'b1;
    random_phase(PHASE_BEATS);

    // A write past the last register must leave the circle alone.
    reg_write(REG_SPARE, $urandom);
    sink_steady = 1'b0;
    random_phase(PHASE_BEATS);

    set_circle(0, 0, 1);
    random_phase(PHASE_BEATS);

    // Both sides flat out, then back to random idling.
    set_circle($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
               $urandom_range(0, 2000));
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    random_phase(PHASE_BEATS / 2);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    random_phase(PHASE_BEATS / 2);

    // Allow for the pipeline depth before wrapping up.
    repeat (12) @(posedge clk_i);
    if (expected_hits.size() != 0) begin
      error_count += expected_hits.size();
      $display("%0d predicted results never arrived.", expected_hits.size());
    end

    $display("Ran %0d queries (%0d point, %0d segment, %0d circle, %0d spare code) %s %0d.",
             beats_in, cmd_count[cct_pkg::CMD_POINT], cmd_count[cct_pkg::CMD_SEGMENT],
             cmd_count[cct_pkg::CMD_CIRCLE], cmd_count[cct_pkg::CMD_UNUSED],
             "with circle setups numbering", circle_setups);
    $display("Checked %0d results, %0d of them hits; %0d mismatches.",
             beats_out, hits_seen, error_count);
    if (error_count == 0) begin
      $display("circle_collision_test_core_tb OK");
    end else begin
      $display("circle_collision_test_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cct_pkg.sv
sv/cct_wide_mul.sv
sv/circle_collision_test_core.sv
sv/cct_checker.sv
tb/circle_collision_test_core_tb.sv
